// ===== rtl/cpm_pkg.sv =====
package cpm_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 16;

    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int DIST_W  = COORD_BITS + 1;
    localparam int POINT_W = 2 * COORD_BITS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD_A,
        S_CAP_A,
        S_SCAN,
        S_FLUSH1,
        S_FLUSH2,
        S_PUBLISH
    } cpm_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // store the incoming point
        logic row_init;   // i <= 0
        logic row_next;   // i <= i + 1
        logic rd_a;       // read entry i
        logic cap_a;      // capture entry i as point a
        logic col_init;   // j <= 0
        logic scan;       // read entry j, advance j
        logic publish;    // move best pair to the output register, clear search
    } cpm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic few_points; // fewer than two points stored
        logic row_last;   // i is the last stored entry
        logic col_last;   // j is the last stored entry
        logic out_full;   // output register holds an untaken result
    } cpm_sts_t;

endpackage

// ===== rtl/cpm_ram.sv =====
module cpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/cpm_ctrl.sv =====
module cpm_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_last,
    input  logic              out_ready,
    output logic              in_ready,
    output cpm_pkg::cpm_cmd_t cmd,
    input  cpm_pkg::cpm_sts_t sts
);
    import cpm_pkg::*;

    cpm_state_t state_reg;
    cpm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_last)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                if (sts.few_points)
                begin
                    state_next = S_PUBLISH;
                end
                else
                begin
                    cmd.row_init = 1'b1;
                    state_next   = S_RD_A;
                end
            end
            S_RD_A:
            begin
                cmd.rd_a   = 1'b1;
                state_next = S_CAP_A;
            end
            S_CAP_A:
            begin
                cmd.cap_a    = 1'b1;
                cmd.col_init = 1'b1;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.col_last)
                begin
                    if (sts.row_last)
                    begin
                        state_next = S_FLUSH1;
                    end
                    else
                    begin
                        cmd.row_next = 1'b1;
                        state_next   = S_RD_A;
                    end
                end
            end
            S_FLUSH1:
            begin
                state_next = S_FLUSH2;
            end
            S_FLUSH2:
            begin
                state_next = S_PUBLISH;
            end
            S_PUBLISH:
            begin
                if (!sts.out_full || out_ready)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/cpm_dp.sv =====
module cpm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cpm_pkg::cpm_cmd_t                   cmd,
    output cpm_pkg::cpm_sts_t                   sts,
    input  logic signed [cpm_pkg::COORD_BITS-1:0] in_x,
    input  logic signed [cpm_pkg::COORD_BITS-1:0] in_y,
    input  logic                                out_take,
    output logic                                out_valid,
    output logic                                out_pair,
    output logic [cpm_pkg::DIST_W-1:0]          out_dist,
    output logic signed [cpm_pkg::COORD_BITS-1:0] out_ax,
    output logic signed [cpm_pkg::COORD_BITS-1:0] out_ay,
    output logic signed [cpm_pkg::COORD_BITS-1:0] out_bx,
    output logic signed [cpm_pkg::COORD_BITS-1:0] out_by
);
    import cpm_pkg::*;

    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] i_reg;
    logic [ADDR_W-1:0] j_reg;
    logic              store_room;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [POINT_W-1:0] ram_rd_data;
    logic [CNT_W-1:0]  last_idx;

    logic signed [COORD_BITS-1:0] ax_reg, ay_reg;
    logic                         tag1_reg;

    // stage 2 registers
    logic                         tag2_reg;
    logic [DIST_W-1:0]            d2_reg;
    logic signed [COORD_BITS-1:0] ax2_reg, ay2_reg, bx2_reg, by2_reg;

    // running best
    logic                         found_reg;
    logic [DIST_W-1:0]            best_d_reg;
    logic signed [COORD_BITS-1:0] best_ax_reg, best_ay_reg, best_bx_reg, best_by_reg;

    logic                         out_valid_reg;
    logic                         out_valid_next;

    logic signed [COORD_BITS-1:0] bx1, by1;
    logic signed [COORD_BITS:0]   diff_x, diff_y;
    logic [COORD_BITS-1:0]        mag_x, mag_y;
    logic [DIST_W-1:0]            d1;
    logic                         a_less, a_equal, b_less, take;

    assign store_room  = count_reg < CNT_W'(MAX_POINTS);
    assign ram_rd_en   = cmd.rd_a | cmd.scan;
    assign ram_rd_addr = cmd.rd_a ? i_reg : j_reg;
    assign last_idx    = count_reg - CNT_W'(1);

    cpm_ram #(
        .WIDTH(POINT_W),
        .DEPTH(MAX_POINTS)
    ) u_store (
        .clk    (clk),
        .wr_en  (cmd.load & store_room),
        .wr_addr(count_reg[ADDR_W-1:0]),
        .wr_data({in_y, in_x}),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign sts.few_points = count_reg < CNT_W'(2);
    assign sts.row_last   = CNT_W'(i_reg) == last_idx;
    assign sts.col_last   = CNT_W'(j_reg) == last_idx;
    assign sts.out_full   = out_valid_reg;

    // stage 1: Manhattan distance of a and the entry just read
    assign bx1    = ram_rd_data[COORD_BITS-1:0];
    assign by1    = ram_rd_data[POINT_W-1:COORD_BITS];
    assign diff_x = {ax_reg[COORD_BITS-1], ax_reg} - {bx1[COORD_BITS-1], bx1};
    assign diff_y = {ay_reg[COORD_BITS-1], ay_reg} - {by1[COORD_BITS-1], by1};
    assign mag_x  = diff_x[COORD_BITS] ? COORD_BITS'(-diff_x) : diff_x[COORD_BITS-1:0];
    assign mag_y  = diff_y[COORD_BITS] ? COORD_BITS'(-diff_y) : diff_y[COORD_BITS-1:0];
    assign d1     = {1'b0, mag_x} + {1'b0, mag_y};

    // stage 2: keep the least (distance, a, b) by x then y
    assign a_less  = (ax2_reg < best_ax_reg) ||
                     ((ax2_reg == best_ax_reg) && (ay2_reg < best_ay_reg));
    assign a_equal = (ax2_reg == best_ax_reg) && (ay2_reg == best_ay_reg);
    assign b_less  = (bx2_reg < best_bx_reg) ||
                     ((bx2_reg == best_bx_reg) && (by2_reg < best_by_reg));
    assign take    = tag2_reg &&
                     (!found_reg || (d2_reg < best_d_reg) ||
                      ((d2_reg == best_d_reg) && (a_less || (a_equal && b_less))));

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            tag1_reg      <= 1'b0;
            tag2_reg      <= 1'b0;
            found_reg     <= 1'b0;
            best_d_reg    <= '1;
            best_ax_reg   <= '0;
            best_ay_reg   <= '0;
            best_bx_reg   <= '0;
            best_by_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            tag1_reg      <= cmd.scan && (j_reg != i_reg);
            tag2_reg      <= tag1_reg;

            if (cmd.load && store_room)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.row_init)
            begin
                i_reg <= '0;
            end
            else if (cmd.row_next)
            begin
                i_reg <= i_reg + ADDR_W'(1);
            end
            if (cmd.col_init)
            begin
                j_reg <= '0;
            end
            else if (cmd.scan)
            begin
                j_reg <= j_reg + ADDR_W'(1);
            end

            if (cmd.publish)
            begin
                count_reg   <= '0;
                found_reg   <= 1'b0;
                best_d_reg  <= '1;
                best_ax_reg <= '0;
                best_ay_reg <= '0;
                best_bx_reg <= '0;
                best_by_reg <= '0;
            end
            else if (take)
            begin
                found_reg   <= 1'b1;
                best_d_reg  <= d2_reg;
                best_ax_reg <= ax2_reg;
                best_ay_reg <= ay2_reg;
                best_bx_reg <= bx2_reg;
                best_by_reg <= by2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            ax_reg <= bx1;
            ay_reg <= by1;
        end
        d2_reg  <= d1;
        ax2_reg <= ax_reg;
        ay2_reg <= ay_reg;
        bx2_reg <= bx1;
        by2_reg <= by1;
        if (cmd.publish)
        begin
            out_pair <= found_reg;
            out_dist <= found_reg ? best_d_reg : '0;
            out_ax   <= best_ax_reg;
            out_ay   <= best_ay_reg;
            out_bx   <= best_bx_reg;
            out_by   <= best_by_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_publish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("published result not presented");

    a_nomin_dist: assert property (@(posedge clk) disable iff (!rst_n)
        !found_reg |-> (best_d_reg == '1))
        else $error("distance changed without a pair");

    a_clear_after_publish: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> (count_reg == '0) && !found_reg)
        else $error("search state not cleared after publish");
`endif

endmodule

// ===== rtl/closest_pair_manhattan_core.sv =====
// Closest pair of points under the Manhattan metric, brute-force search.
//
// Input stream: each transfer carries one point (x, y). The transfer with
// tlast high closes the set and starts the search. Up to MAX_POINTS points
// are stored; points beyond that are dropped (the closing one included),
// and the search runs over what is stored.
// Output stream: one transfer per closed set, with tuser = 1 when at least
// two points were stored. Ties resolve to the least first point (by x, then
// y) of any minimal pair, and then its least partner. Without a pair all
// data fields read zero.
// Points load one per cycle while s_axis_tready is high. After the closing
// transfer with N >= 2 stored points, each of the N rows fetches its first
// point and then streams all N stored points as partners through the single
// read port of the point store; with fewer points the search is skipped.
// s_axis_tready stays low for the whole search. The result sits in an output
// register; loading of the next set starts right away while it waits. A
// stalled receiver holds off the next result, which waits until the previous
// one is taken, and s_axis_tready stays low while it waits.
// Reset (rst_n low, asynchronous) empties the set and drops any pending
// result; the point store needs no clearing.
module closest_pair_manhattan_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] point_x, [31:16] point_y
    input  logic        s_axis_tlast,   // last_point
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // [16:0] min_distance, [32:17] first_x,
                                        // [48:33] first_y, [64:49] second_x,
                                        // [80:65] second_y, [87:81] zero
    output logic        m_axis_tuser    // valid_pair
);
    import cpm_pkg::*;

    cpm_cmd_t cmd;
    cpm_sts_t sts;

    logic [DIST_W-1:0]            res_dist;
    logic signed [COORD_BITS-1:0] res_ax, res_ay, res_bx, res_by;
    logic                         res_valid;

    // FSM sequences load, row fetch, partner scan, pipeline flush, publish
    cpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_last  (s_axis_tlast),
        .out_ready(m_axis_tready),
        .in_ready (s_axis_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // point store, distance pipeline, running best and output register
    cpm_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_x     (s_axis_tdata[15:0]),
        .in_y     (s_axis_tdata[31:16]),
        .out_take (m_axis_tready),
        .out_valid(res_valid),
        .out_pair (m_axis_tuser),
        .out_dist (res_dist),
        .out_ax   (res_ax),
        .out_ay   (res_ay),
        .out_bx   (res_bx),
        .out_by   (res_by)
    );

    assign m_axis_tvalid = res_valid;
    assign m_axis_tdata  = {7'd0, res_by, res_bx, res_ay, res_ax, res_dist};

endmodule
